// ===== design/ftw_pkg.sv =====
`timescale 1ns / 1ps
package ftw_pkg;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 24;

	localparam logic [15:0] NINE_TENTHS_Q15 = 16'd29491;
	localparam logic [63:0] ONE_Q30         = 64'd1 << 30;

	typedef enum logic [2:0] {
		REG_HP_A1      = 3'd0,
		REG_HP_B0      = 3'd1,
		REG_LP_A1      = 3'd2,
		REG_LP_B0      = 3'd3,
		REG_DRIVE_GAIN = 3'd4,
		REG_OUT_VOLUME = 3'd5,
		REG_DRY_MIX    = 3'd6,
		REG_WET_MIX    = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic              channel;
		logic signed [23:0] sample_in;
	} smp_t;

	typedef struct packed {
		logic              channel_out;
		logic signed [23:0] sample_out;
	} res_t;

	typedef struct packed {
		logic signed [23:0] hp_a1;
		logic signed [23:0] hp_b0;
		logic signed [23:0] lp_a1;
		logic signed [23:0] lp_b0;
		logic [22:0]        drive_gain;
		logic [22:0]        out_volume;
		logic [15:0]        dry_mix;
		logic [15:0]        wet_mix;
	} cfg_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_HP_MB,
		ST_HP_Y,
		ST_HP_MA,
		ST_HP_V,
		ST_ARG,
		ST_MAG,
		ST_IDX_M,
		ST_IDX,
		ST_RD0,
		ST_RD1,
		ST_DIFF,
		ST_INTERP_M,
		ST_TANH,
		ST_SCALE_M,
		ST_NL,
		ST_LP_MB,
		ST_LP_Y,
		ST_LP_MA,
		ST_LP_V,
		ST_MIX_W,
		ST_MIX_A,
		ST_MIX,
		ST_VOL_M,
		ST_DONE
	} state_t;

	typedef enum logic [3:0] {
		MUL_NONE,
		MUL_HP_B0,
		MUL_HP_A1,
		MUL_DRIVE,
		MUL_INDEX,
		MUL_INTERP,
		MUL_SCALE,
		MUL_LP_B0,
		MUL_LP_A1,
		MUL_DRY,
		MUL_WET,
		MUL_VOLUME
	} mul_sel_t;

	typedef enum logic [2:0] {
		ACC_HOLD,
		ACC_LOAD,
		ACC_LOAD_NEG,
		ACC_ADD,
		ACC_SUB
	} acc_op_t;

	typedef struct packed {
		mul_sel_t mul_sel;
		acc_op_t  acc_op;
		logic     ld_in;
		logic     ld_yh;
		logic     wr_hp;
		logic     ld_arg;
		logic     ld_mag;
		logic     ld_idx;
		logic     rom_next;
		logic     ld_t0;
		logic     ld_diff;
		logic     ld_tanh;
		logic     ld_nl;
		logic     ld_yl;
		logic     wr_lp;
		logic     ld_mix;
		logic     ld_res;
		logic     res_zero;
	} cmd_t;

	typedef struct packed {
		logic ch_ok;
	} stat_t;

	// shift-subtract long division, only evaluated while building the table
	function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] q;
		logic [63:0] r;
		q = '0;
		r = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[62:0], a[i]};
			if (r >= b) begin
				r    = r - b;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// tanh at 8k/depth in unsigned q.23, via e^(-2x) = (e^(-k/depth))^16
	function automatic logic [22:0] tanh_point(input int unsigned k, input int unsigned depth);
		logic [63:0] z;
		logic [63:0] term;
		logic [63:0] pos;
		logic [63:0] neg;
		logic [63:0] r;
		logic [63:0] num;
		logic [63:0] den;
		logic [63:0] q;
		z    = udiv64(64'(k) << 30, 64'(depth));
		term = ONE_Q30;
		pos  = ONE_Q30;
		neg  = '0;
		for (int n = 1; n <= 16; n++) begin
			term = udiv64((term * z) >> 30, 64'(n));
			if ((n & 1) != 0) begin
				neg = neg + term;
			end else begin
				pos = pos + term;
			end
		end
		r = (pos > neg) ? pos - neg : '0;
		if (r > ONE_Q30) begin
			r = ONE_Q30;
		end
		for (int i = 0; i < 4; i++) begin
			r = (r * r + (64'd1 << 29)) >> 30;
		end
		num = ONE_Q30 - r;
		den = ONE_Q30 + r;
		q   = udiv64((num << 23) + (den >> 1), den);
		return q[22:0];
	endfunction

endpackage

// ===== design/filtered_tanh_waveshaper.sv =====
`timescale 1ns / 1ps
// channel   signals                         request
// sample    smp_valid / smp_ready / smp      channel, sample_in
// result    res_valid / res_ready / res      channel_out, sample_out
// config    cfg_we / cfg_idx / cfg_wdata     one register write per cycle
//
// one sample goes from acceptance to the result register in eleven passes
// through the single shared multiplier plus two reads of the tanh rom.
// a sample with an out-of-range channel goes straight from idle to the done
// state and returns zero.
// ready comes back in the cycle after the result is loaded; a full output
// register stalls only the final load.
// reset clears filter and control state and sets config registers to defaults.
module filtered_tanh_waveshaper #(
	parameter int unsigned CHANNELS         = 2,
	parameter int unsigned TANH_TABLE_DEPTH = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            smp_valid,
	output logic                            smp_ready,
	input  ftw_pkg::smp_t                   smp,
	output logic                            res_valid,
	input  logic                            res_ready,
	output ftw_pkg::res_t                   res,
	input  logic                            cfg_we,
	input  logic [ftw_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [ftw_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	import ftw_pkg::*;

	cfg_t  cfg;
	cmd_t  cmd;
	stat_t stat;

	ftw_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	ftw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.smp_valid (smp_valid),
		.smp_ready (smp_ready),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	ftw_dp #(
		.CHANNELS         (CHANNELS),
		.TANH_TABLE_DEPTH (TANH_TABLE_DEPTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cmd    (cmd),
		.stat   (stat),
		.smp    (smp),
		.res    (res)
	);

`ifndef SYNTHESIS
	// one sample in flight at a time
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		smp_valid && smp_ready |=> !smp_ready)
		else $error("second request accepted while a sample is in flight");

	// filter state only moves while a sample is being processed
	a_state_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_hp || cmd.wr_lp) |-> !smp_ready)
		else $error("filter state written while idle");

	// a new result never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ld_res |-> (!res_valid || res_ready))
		else $error("pending result overwritten");
`endif

endmodule

// ===== design/ftw_cfg.sv =====
`timescale 1ns / 1ps
module ftw_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [ftw_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [ftw_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	output ftw_pkg::cfg_t                       cfg
);
	import ftw_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hp_a1      <= '0;
			cfg_q.hp_b0      <= 24'sd4194304;
			cfg_q.lp_a1      <= '0;
			cfg_q.lp_b0      <= 24'sd4194304;
			cfg_q.drive_gain <= 23'd65536;
			cfg_q.out_volume <= 23'd65536;
			cfg_q.dry_mix    <= '0;
			cfg_q.wet_mix    <= 16'd32768;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_HP_A1:      cfg_q.hp_a1      <= $signed(cfg_wdata);
				REG_HP_B0:      cfg_q.hp_b0      <= $signed(cfg_wdata);
				REG_LP_A1:      cfg_q.lp_a1      <= $signed(cfg_wdata);
				REG_LP_B0:      cfg_q.lp_b0      <= $signed(cfg_wdata);
				REG_DRIVE_GAIN: cfg_q.drive_gain <= cfg_wdata[22:0];
				REG_OUT_VOLUME: cfg_q.out_volume <= cfg_wdata[22:0];
				REG_DRY_MIX:    cfg_q.dry_mix    <= cfg_wdata[15:0];
				REG_WET_MIX:    cfg_q.wet_mix    <= cfg_wdata[15:0];
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== design/ftw_dp.sv =====
`timescale 1ns / 1ps
module ftw_dp #(
	parameter int unsigned CHANNELS         = 2,
	parameter int unsigned TANH_TABLE_DEPTH = 256
) (
	input  logic            clk,
	input  logic            arst_n,
	input  ftw_pkg::cfg_t   cfg,
	input  ftw_pkg::cmd_t   cmd,
	output ftw_pkg::stat_t  stat,
	input  ftw_pkg::smp_t   smp,
	output ftw_pkg::res_t   res
);
	import ftw_pkg::*;

	localparam int unsigned CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int unsigned LUT_N = TANH_TABLE_DEPTH + 1;
	localparam int unsigned AW    = $clog2(TANH_TABLE_DEPTH + 1);

	// round half up, then arithmetic shift
	function automatic logic signed [63:0] rsh(input logic signed [63:0] v, input int unsigned s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -64'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
		if (v > 64'sd8388607) begin
			return 24'sh7fffff;
		end else if (v < -64'sd8388608) begin
			return 24'sh800000;
		end
		return v[23:0];
	endfunction

	// tanh table, constant
	logic [22:0] lut [LUT_N];

	for (genvar k = 0; k < LUT_N; k++) begin : g_lut
		localparam logic [22:0] PT = tanh_point(k, TANH_TABLE_DEPTH);
		assign lut[k] = PT;
	end

	logic signed [23:0] x_q;
	logic               ch_q;
	logic signed [31:0] hp_mem_q [CHANNELS];
	logic signed [31:0] lp_mem_q [CHANNELS];
	logic signed [60:0] prod_q;
	logic signed [63:0] acc_q;
	logic signed [31:0] yh_q;
	logic signed [31:0] yl_q;
	logic signed [39:0] arg_q;
	logic               neg_q;
	logic               big_q;
	logic [25:0]        ua_q;
	logic [AW-1:0]      idx_q;
	logic [26:0]        frac_q;
	logic [22:0]        rom_q;
	logic [22:0]        t0_q;
	logic signed [24:0] diff_q;
	logic signed [23:0] tanh_q;
	logic signed [23:0] nl_q;
	logic signed [33:0] mix_q;
	res_t               res_q;

	logic [CH_W-1:0]    ch_sel;
	logic signed [33:0] mul_a;
	logic signed [26:0] mul_b;
	logic signed [63:0] prod_w;
	logic signed [63:0] r22_prod;
	logic signed [63:0] r16_prod;
	logic signed [63:0] r15_prod;
	logic signed [63:0] r26_prod;
	logic signed [63:0] r22_acc;
	logic signed [63:0] r15_acc;
	logic signed [63:0] hp_cur;
	logic signed [63:0] lp_cur;
	logic [39:0]        mag;
	logic signed [25:0] interp;
	logic [AW-1:0]      rom_addr;

	assign stat.ch_ok = (32'(smp.channel) < CHANNELS);

	assign ch_sel = CH_W'(ch_q);
	assign hp_cur = 64'(hp_mem_q[ch_sel]);
	assign lp_cur = 64'(lp_mem_q[ch_sel]);

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.mul_sel)
			MUL_HP_B0: begin
				mul_a = 34'($signed(cfg.hp_b0));
				mul_b = 27'(x_q);
			end
			MUL_HP_A1: begin
				mul_a = 34'(yh_q);
				mul_b = 27'($signed(cfg.hp_a1));
			end
			MUL_DRIVE: begin
				mul_a = 34'(yh_q);
				mul_b = $signed({4'b0, cfg.drive_gain});
			end
			MUL_INDEX: begin
				mul_a = $signed({8'b0, ua_q});
				mul_b = 27'(TANH_TABLE_DEPTH);
			end
			MUL_INTERP: begin
				mul_a = $signed({7'b0, frac_q});
				mul_b = 27'(diff_q);
			end
			MUL_SCALE: begin
				mul_a = 34'(tanh_q);
				mul_b = $signed({11'b0, NINE_TENTHS_Q15});
			end
			MUL_LP_B0: begin
				mul_a = 34'(nl_q);
				mul_b = 27'($signed(cfg.lp_b0));
			end
			MUL_LP_A1: begin
				mul_a = 34'(yl_q);
				mul_b = 27'($signed(cfg.lp_a1));
			end
			MUL_DRY: begin
				mul_a = 34'(x_q);
				mul_b = $signed({11'b0, cfg.dry_mix});
			end
			MUL_WET: begin
				mul_a = 34'(yl_q);
				mul_b = $signed({11'b0, cfg.wet_mix});
			end
			MUL_VOLUME: begin
				mul_a = mix_q;
				mul_b = $signed({4'b0, cfg.out_volume});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod_w   = 64'(prod_q);
	assign r22_prod = rsh(prod_w, 22);
	assign r16_prod = rsh(prod_w, 16);
	assign r15_prod = rsh(prod_w, 15);
	assign r26_prod = rsh(prod_w, 26);
	assign r22_acc  = rsh(acc_q, 22);
	assign r15_acc  = rsh(acc_q, 15);

	assign mag      = arg_q[39] ? 40'(-arg_q) : 40'(arg_q);
	assign interp   = $signed({3'b0, t0_q}) + 26'(r26_prod);
	assign rom_addr = cmd.rom_next ? idx_q + AW'(1) : idx_q;

	// filter state, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				hp_mem_q[i] <= '0;
				lp_mem_q[i] <= '0;
			end
		end else begin
			if (cmd.wr_hp) begin
				hp_mem_q[ch_sel] <= sat32(r22_acc);
			end
			if (cmd.wr_lp) begin
				lp_mem_q[ch_sel] <= sat32(r22_acc);
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		rom_q  <= lut[rom_addr];

		case (cmd.acc_op)
			ACC_LOAD:     acc_q <= prod_w;
			ACC_LOAD_NEG: acc_q <= -prod_w;
			ACC_ADD:      acc_q <= acc_q + prod_w;
			ACC_SUB:      acc_q <= acc_q - prod_w;
			default:      acc_q <= acc_q;
		endcase

		if (cmd.ld_in) begin
			x_q  <= smp.sample_in;
			ch_q <= smp.channel;
		end
		if (cmd.ld_yh) begin
			yh_q <= sat32(r22_prod + hp_cur);
		end
		if (cmd.ld_arg) begin
			arg_q <= r16_prod[39:0];
		end
		if (cmd.ld_mag) begin
			neg_q <= arg_q[39];
			big_q <= |mag[39:26];
			ua_q  <= mag[25:0];
		end
		// magnitude of 8.0 or more lands exactly on the last table entry
		if (cmd.ld_idx) begin
			if (big_q) begin
				idx_q  <= AW'(TANH_TABLE_DEPTH - 1);
				frac_q <= 27'd1 << 26;
			end else begin
				idx_q  <= prod_q[26 +: AW];
				frac_q <= {1'b0, prod_q[25:0]};
			end
		end
		if (cmd.ld_t0) begin
			t0_q <= rom_q;
		end
		if (cmd.ld_diff) begin
			diff_q <= $signed({2'b0, rom_q}) - $signed({2'b0, t0_q});
		end
		if (cmd.ld_tanh) begin
			tanh_q <= neg_q ? 24'(-interp) : 24'(interp);
		end
		if (cmd.ld_nl) begin
			nl_q <= r15_prod[23:0];
		end
		if (cmd.ld_yl) begin
			yl_q <= sat32(r22_prod + lp_cur);
		end
		if (cmd.ld_mix) begin
			mix_q <= r15_acc[33:0];
		end
		if (cmd.ld_res) begin
			res_q.channel_out <= ch_q;
			res_q.sample_out  <= cmd.res_zero ? '0 : sat24(r16_prod);
		end
	end

	assign res = res_q;

endmodule

// ===== design/ftw_ctrl.sv =====
`timescale 1ns / 1ps
module ftw_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           smp_valid,
	output logic           smp_ready,
	output logic           res_valid,
	input  logic           res_ready,
	input  ftw_pkg::stat_t stat,
	output ftw_pkg::cmd_t  cmd
);
	import ftw_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   zero_q;
	logic   zero_d;
	logic   res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			zero_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			zero_q  <= zero_d;
			if (cmd.ld_res) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d      = state_q;
		zero_d       = zero_q;
		cmd          = '0;
		cmd.mul_sel  = MUL_NONE;
		cmd.acc_op   = ACC_HOLD;
		unique case (state_q)
			ST_IDLE: begin
				if (smp_valid) begin
					cmd.ld_in = 1'b1;
					zero_d    = !stat.ch_ok;
					state_d   = stat.ch_ok ? ST_HP_MB : ST_DONE;
				end
			end
			ST_HP_MB: begin
				cmd.mul_sel = MUL_HP_B0;
				state_d     = ST_HP_Y;
			end
			ST_HP_Y: begin
				cmd.ld_yh  = 1'b1;
				cmd.acc_op = ACC_LOAD_NEG;
				state_d    = ST_HP_MA;
			end
			ST_HP_MA: begin
				cmd.mul_sel = MUL_HP_A1;
				state_d     = ST_HP_V;
			end
			ST_HP_V: begin
				cmd.acc_op  = ACC_SUB;
				cmd.mul_sel = MUL_DRIVE;
				state_d     = ST_ARG;
			end
			ST_ARG: begin
				cmd.wr_hp  = 1'b1;
				cmd.ld_arg = 1'b1;
				state_d    = ST_MAG;
			end
			ST_MAG: begin
				cmd.ld_mag = 1'b1;
				state_d    = ST_IDX_M;
			end
			ST_IDX_M: begin
				cmd.mul_sel = MUL_INDEX;
				state_d     = ST_IDX;
			end
			ST_IDX: begin
				cmd.ld_idx = 1'b1;
				state_d    = ST_RD0;
			end
			ST_RD0: begin
				state_d = ST_RD1;
			end
			ST_RD1: begin
				cmd.ld_t0    = 1'b1;
				cmd.rom_next = 1'b1;
				state_d      = ST_DIFF;
			end
			ST_DIFF: begin
				cmd.ld_diff = 1'b1;
				state_d     = ST_INTERP_M;
			end
			ST_INTERP_M: begin
				cmd.mul_sel = MUL_INTERP;
				state_d     = ST_TANH;
			end
			ST_TANH: begin
				cmd.ld_tanh = 1'b1;
				state_d     = ST_SCALE_M;
			end
			ST_SCALE_M: begin
				cmd.mul_sel = MUL_SCALE;
				state_d     = ST_NL;
			end
			ST_NL: begin
				cmd.ld_nl = 1'b1;
				state_d   = ST_LP_MB;
			end
			ST_LP_MB: begin
				cmd.mul_sel = MUL_LP_B0;
				state_d     = ST_LP_Y;
			end
			ST_LP_Y: begin
				cmd.ld_yl  = 1'b1;
				cmd.acc_op = ACC_LOAD;
				state_d    = ST_LP_MA;
			end
			ST_LP_MA: begin
				cmd.mul_sel = MUL_LP_A1;
				state_d     = ST_LP_V;
			end
			ST_LP_V: begin
				cmd.acc_op  = ACC_SUB;
				cmd.mul_sel = MUL_DRY;
				state_d     = ST_MIX_W;
			end
			ST_MIX_W: begin
				cmd.wr_lp   = 1'b1;
				cmd.acc_op  = ACC_LOAD;
				cmd.mul_sel = MUL_WET;
				state_d     = ST_MIX_A;
			end
			ST_MIX_A: begin
				cmd.acc_op = ACC_ADD;
				state_d    = ST_MIX;
			end
			ST_MIX: begin
				cmd.ld_mix = 1'b1;
				state_d    = ST_VOL_M;
			end
			ST_VOL_M: begin
				cmd.mul_sel = MUL_VOLUME;
				state_d     = ST_DONE;
			end
			ST_DONE: begin
				// keep the volume product alive while the output register is full
				cmd.mul_sel = MUL_VOLUME;
				if (!res_valid_q || res_ready) begin
					cmd.ld_res   = 1'b1;
					cmd.res_zero = zero_q;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign smp_ready = (state_q == ST_IDLE);
	assign res_valid = res_valid_q;

endmodule
